FILE: sv/tlbfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbfl_pkg - shared definitions of the translation buffer
// field widths, command and register codes, controller/datapath structs
// ----------------------------------------------------------------------------
package tlbfl_pkg;

    // physical slots by default
    localparam int ENTRIES_DEFAULT = 32;

    // beat field widths
    localparam int CMD_W   = 2;
    localparam int PID_W   = 16;
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int EIU_W      = 6;

    localparam logic [EIU_W-1:0] EIU_RESET = 6'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LRU    = 1'd1;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: sv/tlbfl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbfl_if - request and result channels of the translation buffer
// valid/ready channels carrying one beat each
// ----------------------------------------------------------------------------
interface tlbfl_in_if;
    logic                         valid;
    logic                         ready;
    logic [tlbfl_pkg::CMD_W-1:0]   command;
    logic [tlbfl_pkg::PID_W-1:0]   process_id;
    logic [tlbfl_pkg::PAGE_W-1:0]  page_number;
    logic [tlbfl_pkg::FRAME_W-1:0] frame_number;

    modport source (output valid, output command, output process_id,
                    output page_number, output frame_number, input ready);
    modport sink   (input valid, input command, input process_id,
                    input page_number, input frame_number, output ready);
endinterface

interface tlbfl_out_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [tlbfl_pkg::FRAME_W-1:0] frame_found;
    logic                         evicted;
    logic [tlbfl_pkg::PID_W-1:0]   evicted_pid;
    logic [tlbfl_pkg::PAGE_W-1:0]  evicted_page;
    logic [tlbfl_pkg::FRAME_W-1:0] evicted_frame;

    modport source (output valid, output hit, output frame_found, output evicted,
                    output evicted_pid, output evicted_page, output evicted_frame,
                    input ready);
    modport sink   (input valid, input hit, input frame_found, input evicted,
                    input evicted_pid, input evicted_page, input evicted_frame,
                    output ready);
endinterface
`default_nettype wire

FILE: sv/tlbfl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbfl_ctrl - sequencer of the translation buffer
// steps each request through compare, optional victim scan and commit
// ----------------------------------------------------------------------------
module tlbfl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tlbfl_pkg::t_dp_sts i_sts,
    output tlbfl_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CMP    = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       load;

    // a new beat may enter while the previous one commits
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_COMMIT) && i_sts.out_free);
    assign load       = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load      = load;
        o_cmd.compare   = (r_state == S_CMP);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.commit    = (r_state == S_COMMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (load) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = i_sts.need_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (load) n_state = S_CMP;
                else if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tlbfl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbfl_dp - entry store, key compare, recency ranks and result register
// register-held entries compared in parallel, updated on commit
// ----------------------------------------------------------------------------
module tlbfl_dp #(
    parameter int ENTRIES = tlbfl_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tlbfl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tlbfl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [tlbfl_pkg::CMD_W-1:0]       i_command,
    input  wire logic [tlbfl_pkg::PID_W-1:0]       i_process_id,
    input  wire logic [tlbfl_pkg::PAGE_W-1:0]      i_page_number,
    input  wire logic [tlbfl_pkg::FRAME_W-1:0]     i_frame_number,
    input  wire tlbfl_pkg::t_dp_cmd                i_cmd,
    output tlbfl_pkg::t_dp_sts                     o_sts,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_hit,
    output logic [tlbfl_pkg::FRAME_W-1:0]          o_frame_found,
    output logic                                   o_evicted,
    output logic [tlbfl_pkg::PID_W-1:0]            o_evicted_pid,
    output logic [tlbfl_pkg::PAGE_W-1:0]           o_evicted_page,
    output logic [tlbfl_pkg::FRAME_W-1:0]          o_evicted_frame
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int WIDE_W = (CNT_W > tlbfl_pkg::EIU_W) ? CNT_W : tlbfl_pkg::EIU_W;

    // configuration
    logic [tlbfl_pkg::EIU_W-1:0] r_eiu;
    logic                        r_lru;

    // entries
    logic [ENTRIES-1:0]              r_valid;
    logic [tlbfl_pkg::PID_W-1:0]     r_pid   [ENTRIES];
    logic [tlbfl_pkg::PAGE_W-1:0]    r_page  [ENTRIES];
    logic [tlbfl_pkg::FRAME_W-1:0]   r_frame [ENTRIES];
    logic [RANK_W-1:0]               r_rank  [ENTRIES];
    logic [IDX_W-1:0]                r_fp;
    logic [CNT_W-1:0]                r_filled;

    // latched request
    logic [tlbfl_pkg::CMD_W-1:0]     r_cmd;
    logic [tlbfl_pkg::PID_W-1:0]     r_key_pid;
    logic [tlbfl_pkg::PAGE_W-1:0]    r_key_page;
    logic [tlbfl_pkg::FRAME_W-1:0]   r_new_frame;

    // compare results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_victim;
    logic [IDX_W-1:0] r_scan_idx;
    logic [RANK_W-1:0] r_best;

    logic [CNT_W-1:0] cap;
    logic             cap_zero;
    logic             has_free;
    logic             replacing;
    logic [ENTRIES-1:0] match;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] lru_idx;
    logic [IDX_W-1:0] fifo_idx;
    logic [CNT_W-1:0] victim_next;

    logic             touch_en;
    logic [IDX_W-1:0] touch_slot;
    logic [CNT_W-1:0] touch_old;
    logic             is_lookup;
    logic             is_insert;

    // capacity is the smaller of the register and the slot count
    always_comb begin
        logic [WIDE_W-1:0] eiu_w;
        logic [WIDE_W-1:0] ent_w;
        eiu_w = WIDE_W'(r_eiu);
        ent_w = WIDE_W'(ENTRIES);
        cap   = (eiu_w < ent_w) ? CNT_W'(eiu_w) : CNT_W'(ENTRIES);
    end

    assign cap_zero  = (cap == '0);
    assign has_free  = (r_filled < cap);
    assign is_lookup = (r_cmd == tlbfl_pkg::CMD_LOOKUP);
    assign is_insert = (r_cmd == tlbfl_pkg::CMD_INSERT);
    assign replacing = is_insert && !cap_zero && !has_free;

    // per-slot key match, visible slots only
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (CNT_W'(i) < cap) &&
                       (r_pid[i] == r_key_pid) && (r_page[i] == r_key_page);
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) hit_idx = IDX_W'(i);
        end
    end

    // full with no hidden slots: ranks are a permutation, oldest has rank cap-1
    always_comb begin
        lru_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (CNT_W'(i) < cap) &&
                (CNT_W'(r_rank[i]) == (cap - CNT_W'(1)))) lru_idx = IDX_W'(i);
        end
    end

    assign fifo_idx    = (CNT_W'(r_fp) < cap) ? r_fp : '0;
    assign victim_next = CNT_W'(r_victim) + CNT_W'(1);

    always_comb begin
        o_sts.need_scan = replacing && r_lru && (r_filled != cap);
        o_sts.scan_last = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == cap);
        o_sts.out_free  = !o_out_valid || i_out_ready;
    end

    // recency update target on commit
    always_comb begin
        touch_en   = 1'b0;
        touch_slot = '0;
        touch_old  = '0;
        if (is_lookup && r_hit) begin
            touch_en   = 1'b1;
            touch_slot = r_hit_idx;
            touch_old  = CNT_W'(r_rank[r_hit_idx]);
        end else if (is_insert && !cap_zero) begin
            touch_en = 1'b1;
            if (has_free) begin
                touch_slot = IDX_W'(r_filled);
                touch_old  = r_filled;
            end else begin
                touch_slot = r_victim;
                touch_old  = CNT_W'(r_rank[r_victim]);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eiu <= tlbfl_pkg::EIU_RESET;
            r_lru <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlbfl_pkg::CFG_ENTRIES_IN_USE: r_eiu <= i_cfg_data;
                tlbfl_pkg::CFG_REPLACE_LRU:    r_lru <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd       <= i_command;
            r_key_pid   <= i_process_id;
            r_key_page  <= i_page_number;
            r_new_frame <= i_frame_number;
        end
    end

    // compare stage and victim scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_hit      <= |match;
            r_hit_idx  <= hit_idx;
            r_victim   <= o_sts.need_scan ? '0 : (r_lru ? lru_idx : fifo_idx);
            r_scan_idx <= '0;
            r_best     <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_valid[r_scan_idx] && (r_rank[r_scan_idx] >= r_best)) begin
                r_best   <= r_rank[r_scan_idx];
                r_victim <= r_scan_idx;
            end
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
    end

    // entry control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_filled <= '0;
            r_fp     <= '0;
        end else if (i_cmd.commit) begin
            case (r_cmd)
                tlbfl_pkg::CMD_INSERT: begin
                    if (!cap_zero) begin
                        if (has_free) begin
                            r_valid[IDX_W'(r_filled)] <= 1'b1;
                            r_filled <= r_filled + CNT_W'(1);
                        end else if (!r_lru) begin
                            r_fp <= (victim_next < cap) ? IDX_W'(victim_next) : '0;
                        end
                    end
                end
                tlbfl_pkg::CMD_FLUSH: begin
                    r_valid  <= '0;
                    r_filled <= '0;
                    r_fp     <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // entry payload and ranks
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (is_insert && !cap_zero) begin
                r_pid[touch_slot]   <= r_key_pid;
                r_page[touch_slot]  <= r_key_page;
                r_frame[touch_slot] <= r_new_frame;
            end
            if (touch_en) begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (IDX_W'(j) == touch_slot) begin
                        r_rank[j] <= '0;
                    end else if (r_valid[j] && (CNT_W'(r_rank[j]) < touch_old)) begin
                        r_rank[j] <= r_rank[j] + RANK_W'(1);
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit           <= is_lookup && r_hit;
            o_frame_found   <= (is_lookup && r_hit) ? r_frame[r_hit_idx] : '0;
            o_evicted       <= replacing;
            o_evicted_pid   <= replacing ? r_pid[r_victim] : '0;
            o_evicted_page  <= replacing ? r_page[r_victim] : '0;
            o_evicted_frame <= replacing ? r_frame[r_victim] : '0;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tlb_fifo_lru_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_fifo_lru_lookup - fully associative translation buffer
// lookup, insert with fifo or lru replacement, and flush over valid/ready
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  --------  ---------  ---------------------------------------------------
//  i_in      in         command, process_id, page_number, frame_number
//  o_out     out        hit, frame_found, evicted, evicted_pid/page/frame
//  i_cfg_*   in         write enable, register index, data (no handshake)
//
//  lookup, flush, fill of a free slot and replacement with the fill equal
//  to the capacity run back to back as compare, then commit, with the
//  next beat accepted in the commit cycle
//  lru replacement after the capacity was lowered below the fill adds a
//  victim scan that steps through the rank registers of the visible slots
//  a result that is not taken holds the commit and with it the input
//  reset is synchronous; the entry valid bits clear in the same cycle
//
module tlb_fifo_lru_lookup #(
    parameter int ENTRIES = tlbfl_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    tlbfl_in_if.sink                              i_in,
    tlbfl_out_if.source                           o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [tlbfl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tlbfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    tlbfl_pkg::t_dp_cmd dp_cmd;
    tlbfl_pkg::t_dp_sts dp_sts;
    logic               in_ready;

    assign i_in.ready = in_ready;

    tlbfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // entries, compare, rank update and the result register
    tlbfl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_in.command),
        .i_process_id    (i_in.process_id),
        .i_page_number   (i_in.page_number),
        .i_frame_number  (i_in.frame_number),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_hit           (o_out.hit),
        .o_frame_found   (o_out.frame_found),
        .o_evicted       (o_out.evicted),
        .o_evicted_pid   (o_out.evicted_pid),
        .o_evicted_page  (o_out.evicted_page),
        .o_evicted_frame (o_out.evicted_frame)
    );

endmodule
`default_nettype wire

FILE: sv/tlbfl_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlbfl_chk - port checks of the translation buffer
// result ordering against accepted beats and result channel behaviour
// ----------------------------------------------------------------------------
module tlbfl_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            i_in_ready,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire logic                            i_hit,
    input wire logic [tlbfl_pkg::FRAME_W-1:0]   i_frame_found,
    input wire logic                            i_evicted,
    input wire logic [tlbfl_pkg::PID_W-1:0]     i_evicted_pid,
    input wire logic [tlbfl_pkg::PAGE_W-1:0]    i_evicted_page,
    input wire logic [tlbfl_pkg::FRAME_W-1:0]   i_evicted_frame
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // beats accepted whose result is not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit) &&
        $stable(i_frame_found) && $stable(i_evicted) && $stable(i_evicted_pid) &&
        $stable(i_evicted_page) && $stable(i_evicted_frame))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("ready straight after an accepted beat");

    a_no_spare_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != 2'd0))
        else $error("result with no accepted beat");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd3))
        else $error("more than two beats outstanding");

endmodule

bind tlb_fifo_lru_lookup tlbfl_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_hit           (o_out.hit),
    .i_frame_found   (o_out.frame_found),
    .i_evicted       (o_out.evicted),
    .i_evicted_pid   (o_out.evicted_pid),
    .i_evicted_page  (o_out.evicted_page),
    .i_evicted_frame (o_out.evicted_frame)
);
`default_nettype wire
